// ===== hw/rtl/och_pkg.sv =====
// ============================================================================
// Offset correlation histogram package
// Shared widths, payload types and the fixed histogram bin edges.
// ============================================================================
package och_pkg;

    localparam int SAMPLE_WIDTH = 16;
    localparam int COUNT_WIDTH  = 16;
    localparam int BINS         = 20;
    localparam int BIN_W        = $clog2(BINS);

    localparam int SUM_WIDTH    = 40;
    localparam int DIFF_WIDTH   = SAMPLE_WIDTH + 1;
    localparam int MAC_WIDTH    = 2 * DIFF_WIDTH;

    localparam int Q_FRAC       = 14;
    localparam int Q_WIDTH      = Q_FRAC + 1;
    localparam int SIM_WIDTH    = Q_FRAC + 2;
    localparam int BIT_IDX_W    = $clog2(Q_WIDTH);

    localparam int CHUNK_WIDTH  = 10;
    localparam int CHUNKS       = SUM_WIDTH / CHUNK_WIDTH;
    localparam int CHUNK_IDX_W  = $clog2(CHUNKS);
    localparam int PART_WIDTH   = SUM_WIDTH + CHUNK_WIDTH;
    localparam int PROD_WIDTH   = 2 * SUM_WIDTH;
    localparam int ROOT_WIDTH   = PROD_WIDTH + 2 * Q_FRAC + 1;

    localparam int EDGE_WIDTH   = 24;
    localparam int ONE_Q        = 1 << Q_FRAC;
    localparam int LAST_EDGE    = 18022;
    localparam int EDGE_CENTER  = 9;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] x_sample;
        logic signed [SAMPLE_WIDTH-1:0] y_sample;
        logic                           last_sample;
    } t_sample;

    typedef struct packed {
        logic signed [SIM_WIDTH-1:0] similarity;
        logic [BIN_W-1:0]            bin_index;
        logic [COUNT_WIDTH-1:0]      bin_count;
        logic                        flat_vector;
    } t_result;

    typedef struct packed {
        logic [SUM_WIDTH-1:0]        sxx;
        logic [SUM_WIDTH-1:0]        syy;
        logic signed [SUM_WIDTH-1:0] sxy;
    } t_sums;

    typedef struct packed {
        logic signed [SIM_WIDTH-1:0] similarity;
        logic                        flat_vector;
    } t_ratio;

    typedef logic [BINS-1:0][EDGE_WIDTH-1:0] t_edges;

    function automatic t_edges f_bin_edges();
        t_edges e;
        int     n;
        e = '0;
        for (int k = 0; k < BINS; k++) begin
            if (k == BINS - 1) begin
                e[k] = EDGE_WIDTH'(LAST_EDGE);
            end else begin
                n = (k - EDGE_CENTER) * ONE_Q;
                if (n >= 0) begin
                    e[k] = EDGE_WIDTH'((n + 5) / 10);
                end else begin
                    e[k] = EDGE_WIDTH'((n - 5) / 10);
                end
            end
        end
        return e;
    endfunction

    localparam t_edges BIN_EDGES = f_bin_edges();

endpackage

// ===== hw/rtl/och_accum.sv =====
// ============================================================================
// Offset correlation accumulator
// Keeps the reference pair and sums squares and cross products of the
// offsets through one shared signed multiplier, one product per cycle.
// ============================================================================
module och_accum (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic           i_clear,
    input  och_pkg::t_sample i_smp,
    output logic           o_done,
    output och_pkg::t_sums o_sums
);
    import och_pkg::*;

    localparam logic [1:0] PH_XX = 2'd0;
    localparam logic [1:0] PH_YY = 2'd1;
    localparam logic [1:0] PH_XY = 2'd2;

    logic                           r_first;
    logic                           r_busy;
    logic                           r_done;
    logic [1:0]                     r_phase;
    t_sums                          r_sums;
    logic signed [SAMPLE_WIDTH-1:0] r_x_ref;
    logic signed [SAMPLE_WIDTH-1:0] r_y_ref;
    logic signed [SAMPLE_WIDTH-1:0] r_x;
    logic signed [SAMPLE_WIDTH-1:0] r_y;

    logic signed [DIFF_WIDTH-1:0]   w_dx;
    logic signed [DIFF_WIDTH-1:0]   w_dy;
    logic signed [DIFF_WIDTH-1:0]   w_mul_a;
    logic signed [DIFF_WIDTH-1:0]   w_mul_b;
    logic signed [MAC_WIDTH-1:0]    w_mac;
    logic [SUM_WIDTH-1:0]           w_sq_src;
    logic [SUM_WIDTH:0]             w_sq_sum;
    logic [SUM_WIDTH-1:0]           w_sq_sat;
    logic signed [SUM_WIDTH:0]      w_xy_sum;
    logic signed [SUM_WIDTH-1:0]    w_xy_sat;

    always_comb begin
        w_dx = DIFF_WIDTH'(r_x) - DIFF_WIDTH'(r_x_ref);
        w_dy = DIFF_WIDTH'(r_y) - DIFF_WIDTH'(r_y_ref);
        unique case (r_phase)
            PH_XX: begin
                w_mul_a = w_dx;
                w_mul_b = w_dx;
            end
            PH_YY: begin
                w_mul_a = w_dy;
                w_mul_b = w_dy;
            end
            default: begin
                w_mul_a = w_dx;
                w_mul_b = w_dy;
            end
        endcase
        w_mac    = w_mul_a * w_mul_b;
        w_sq_src = (r_phase == PH_XX) ? r_sums.sxx : r_sums.syy;
        w_sq_sum = {1'b0, w_sq_src} + (SUM_WIDTH + 1)'($unsigned(w_mac));
        w_sq_sat = w_sq_sum[SUM_WIDTH] ? '1 : w_sq_sum[SUM_WIDTH-1:0];
        w_xy_sum = (SUM_WIDTH + 1)'(r_sums.sxy) + (SUM_WIDTH + 1)'(w_mac);
        if (w_xy_sum[SUM_WIDTH] != w_xy_sum[SUM_WIDTH-1]) begin
            w_xy_sat = w_xy_sum[SUM_WIDTH] ? {1'b1, {(SUM_WIDTH - 1){1'b0}}}
                                           : {1'b0, {(SUM_WIDTH - 1){1'b1}}};
        end else begin
            w_xy_sat = w_xy_sum[SUM_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first <= 1'b1;
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_phase <= PH_XX;
            r_sums  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_clear) begin
                r_sums  <= '0;
                r_first <= 1'b1;
            end
            if (i_start) begin
                if (r_first) begin
                    r_first <= 1'b0;
                    r_done  <= 1'b1;
                end else begin
                    r_busy  <= 1'b1;
                    r_phase <= PH_XX;
                end
            end
            if (r_busy) begin
                unique case (r_phase)
                    PH_XX: begin
                        r_sums.sxx <= w_sq_sat;
                        r_phase    <= PH_YY;
                    end
                    PH_YY: begin
                        r_sums.syy <= w_sq_sat;
                        r_phase    <= PH_XY;
                    end
                    default: begin
                        r_sums.sxy <= w_xy_sat;
                        r_busy     <= 1'b0;
                        r_done     <= 1'b1;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            if (r_first) begin
                r_x_ref <= i_smp.x_sample;
                r_y_ref <= i_smp.y_sample;
            end else begin
                r_x <= i_smp.x_sample;
                r_y <= i_smp.y_sample;
            end
        end
    end

    assign o_done = r_done;
    assign o_sums = r_sums;

endmodule

// ===== hw/rtl/och_ratio.sv =====
// ============================================================================
// Offset correlation ratio unit
// Forms the two wide products in ten-bit slices on one multiplier, then
// finds the similarity one bit per cycle with a shift-and-subtract root loop.
// ============================================================================
module och_ratio (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  och_pkg::t_sums  i_sums,
    output logic            o_done,
    output och_pkg::t_ratio o_res
);
    import och_pkg::*;

    localparam logic [1:0] RS_IDLE = 2'd0;
    localparam logic [1:0] RS_MUL  = 2'd1;
    localparam logic [1:0] RS_ROOT = 2'd2;
    localparam logic [1:0] RS_SIGN = 2'd3;

    localparam logic [CHUNK_IDX_W-1:0] LAST_CHUNK = CHUNK_IDX_W'(CHUNKS - 1);

    logic [1:0]               r_state;
    logic                     r_done;
    logic                     r_neg;
    logic                     r_second;
    logic [CHUNK_IDX_W-1:0]   r_k;
    logic [BIT_IDX_W-1:0]     r_bit;
    logic [PROD_WIDTH-1:0]    r_acc;
    logic [ROOT_WIDTH-1:0]    r_rem;
    logic [ROOT_WIDTH-1:0]    r_u;
    logic [ROOT_WIDTH-1:0]    r_v;
    logic [Q_WIDTH-1:0]       r_q;
    t_ratio                   r_res;

    logic                     w_neg;
    logic                     w_flat;
    logic [SUM_WIDTH-1:0]     w_abs;
    logic [SUM_WIDTH-1:0]     w_mul_a;
    logic [SUM_WIDTH-1:0]     w_mul_src;
    logic [CHUNK_WIDTH-1:0]   w_mul_b;
    logic [PART_WIDTH-1:0]    w_part;
    logic [PROD_WIDTH-1:0]    w_acc_next;
    logic [ROOT_WIDTH-1:0]    w_d;
    logic [ROOT_WIDTH:0]      w_diff;
    logic                     w_take;
    logic [Q_WIDTH-1:0]       w_q_set;
    logic signed [SIM_WIDTH-1:0] w_mag;
    logic signed [SIM_WIDTH-1:0] w_sim;

    always_comb begin
        w_neg      = i_sums.sxy[SUM_WIDTH-1];
        w_flat     = (i_sums.sxx == '0) || (i_sums.syy == '0);
        w_abs      = w_neg ? (~i_sums.sxy + 1'b1) : i_sums.sxy;
        w_mul_a    = r_second ? i_sums.sxx : w_abs;
        w_mul_src  = r_second ? i_sums.syy : w_abs;
        w_mul_b    = w_mul_src[r_k * CHUNK_WIDTH +: CHUNK_WIDTH];
        w_part     = w_mul_a * w_mul_b;
        w_acc_next = r_acc + (PROD_WIDTH'(w_part) << (r_k * CHUNK_WIDTH));
        w_d        = r_v + r_u;
        w_diff     = {1'b0, r_rem} - {1'b0, w_d};
        w_take     = !w_diff[ROOT_WIDTH] && !r_q[Q_FRAC];
        w_q_set    = r_q | (Q_WIDTH'(1) << r_bit);
        w_mag      = SIM_WIDTH'(r_q);
        w_sim      = r_neg ? -w_mag : w_mag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= RS_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                RS_IDLE: begin
                    if (i_start) begin
                        if (w_flat) begin
                            r_done <= 1'b1;
                        end else begin
                            r_state <= RS_MUL;
                        end
                    end
                end
                RS_MUL: begin
                    if (r_second && (r_k == LAST_CHUNK)) begin
                        r_state <= RS_ROOT;
                    end
                end
                RS_ROOT: begin
                    if (r_bit == '0) begin
                        r_state <= RS_SIGN;
                    end
                end
                default: begin
                    r_state <= RS_IDLE;
                    r_done  <= 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            RS_IDLE: begin
                if (i_start) begin
                    r_res.similarity  <= '0;
                    r_res.flat_vector <= w_flat;
                    r_neg             <= w_neg;
                    r_acc             <= '0;
                    r_second          <= 1'b0;
                    r_k               <= '0;
                    r_bit             <= BIT_IDX_W'(Q_FRAC);
                    r_q               <= '0;
                    r_v               <= '0;
                end
            end
            RS_MUL: begin
                if (r_k == LAST_CHUNK) begin
                    r_k <= '0;
                    if (!r_second) begin
                        r_rem    <= ROOT_WIDTH'(w_acc_next) << (2 * Q_FRAC);
                        r_acc    <= '0;
                        r_second <= 1'b1;
                    end else begin
                        r_u <= ROOT_WIDTH'(w_acc_next) << (2 * Q_FRAC);
                    end
                end else begin
                    r_k   <= r_k + 1'b1;
                    r_acc <= w_acc_next;
                end
            end
            RS_ROOT: begin
                r_u   <= r_u >> 2;
                r_bit <= r_bit - 1'b1;
                if (w_take) begin
                    r_rem <= w_diff[ROOT_WIDTH-1:0];
                    r_v   <= (r_v >> 1) + r_u;
                    r_q   <= w_q_set;
                end else begin
                    r_v <= r_v >> 1;
                end
            end
            default: begin
                r_res.similarity <= w_sim;
            end
        endcase
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

// ===== hw/rtl/och_hist.sv =====
// ============================================================================
// Offset correlation histogram
// Picks the bin for a similarity value and bumps its saturating count.
// ============================================================================
module och_hist (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  och_pkg::t_ratio                 i_res,
    output logic                            o_done,
    output logic [och_pkg::BIN_W-1:0]       o_bin,
    output logic [och_pkg::COUNT_WIDTH-1:0] o_count
);
    import och_pkg::*;

    logic [COUNT_WIDTH-1:0] r_counts [BINS];
    logic                   r_busy;
    logic                   r_done;
    logic [BIN_W-1:0]       r_pick;
    logic [COUNT_WIDTH-1:0] r_count;

    logic [BIN_W-1:0]       w_pick;
    logic [COUNT_WIDTH-1:0] w_cur;
    logic [COUNT_WIDTH-1:0] w_inc;

    always_comb begin
        w_pick = BIN_W'(BINS - 1);
        if (!i_res.flat_vector) begin
            for (int k = BINS - 2; k >= 0; k--) begin
                if ($signed(BIN_EDGES[k]) > EDGE_WIDTH'(i_res.similarity)) begin
                    w_pick = BIN_W'(k);
                end
            end
        end
        w_cur = r_counts[r_pick];
        w_inc = (w_cur == '1) ? w_cur : w_cur + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            for (int k = 0; k < BINS; k++) begin
                r_counts[k] <= '0;
            end
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end
            if (r_busy) begin
                r_busy           <= 1'b0;
                r_done           <= 1'b1;
                r_counts[r_pick] <= w_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_pick <= w_pick;
        end
        if (r_busy) begin
            r_count <= w_inc;
        end
    end

    assign o_done  = r_done;
    assign o_bin   = r_pick;
    assign o_count = r_count;

endmodule

// ===== hw/rtl/offset_correlation_histogram_core.sv =====
// ============================================================================
// Offset correlation histogram core
// Sample pairs go in with a last mark; each vector pair yields one result
// beat with the similarity, its histogram bin, that bin's count and a flag.
// ============================================================================
// The sample channel takes one beat of x, y and a last mark. The first beat
// of a vector sets the reference offsets; every later beat goes through the
// shared 17 by 17 multiplier three times. On a last beat the ratio unit then
// runs: 40 by 10 slices on its multiplier, the root loop (one result bit per
// cycle), a sign step, a hand-off state and the histogram update; the result
// beat turns valid in the same cycle that the next sample beat can be taken.
// A flat vector skips the ratio work.
// The sample channel is ready only while no beat is in work.
// The result sits in an output register; a new sample beat is taken while it
// waits. If the receiver stalls, the next finished vector holds before the
// histogram update until the register is free.
// Reset clears the sums, the histogram counts and the output valid, and the
// next beat after reset starts a new vector.
// ============================================================================
module offset_correlation_histogram_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_smp_valid,
    output logic             o_smp_ready,
    input  och_pkg::t_sample i_smp,
    output logic             o_res_valid,
    input  logic             i_res_ready,
    output och_pkg::t_result o_res
);
    import och_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_ACC   = 3'd1;
    localparam logic [2:0] ST_RATIO = 3'd2;
    localparam logic [2:0] ST_WAIT  = 3'd3;
    localparam logic [2:0] ST_HIST  = 3'd4;

    logic [2:0]             r_state;
    logic                   r_last;
    logic                   r_res_valid;
    t_result                r_res;

    logic                   w_accept;
    logic                   w_out_free;
    logic                   w_hist_start;
    logic                   w_ratio_start;
    logic                   w_acc_done;
    t_sums                  w_sums;
    logic                   w_ratio_done;
    t_ratio                 w_ratio;
    logic                   w_hist_done;
    logic [BIN_W-1:0]       w_bin;
    logic [COUNT_WIDTH-1:0] w_count;

    assign o_smp_ready   = (r_state == ST_IDLE);
    assign w_accept      = i_smp_valid && o_smp_ready;
    assign w_out_free    = !r_res_valid || i_res_ready;
    assign w_hist_start  = (r_state == ST_WAIT) && w_out_free;
    assign w_ratio_start = (r_state == ST_ACC) && w_acc_done && r_last;

    och_accum u_accum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_accept),
        .i_clear (w_hist_start),
        .i_smp   (i_smp),
        .o_done  (w_acc_done),
        .o_sums  (w_sums)
    );

    och_ratio u_ratio (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_ratio_start),
        .i_sums  (w_sums),
        .o_done  (w_ratio_done),
        .o_res   (w_ratio)
    );

    och_hist u_hist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_hist_start),
        .i_res   (w_ratio),
        .o_done  (w_hist_done),
        .o_bin   (w_bin),
        .o_count (w_count)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_res_valid <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_state <= ST_ACC;
                    end
                end
                ST_ACC: begin
                    if (w_acc_done) begin
                        r_state <= r_last ? ST_RATIO : ST_IDLE;
                    end
                end
                ST_RATIO: begin
                    if (w_ratio_done) begin
                        r_state <= ST_WAIT;
                    end
                end
                ST_WAIT: begin
                    if (w_out_free) begin
                        r_state <= ST_HIST;
                    end
                end
                ST_HIST: begin
                    if (w_hist_done) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
            if (w_hist_done) begin
                r_res_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_last <= i_smp.last_sample;
        end
        if (w_hist_done) begin
            r_res.similarity  <= w_ratio.similarity;
            r_res.bin_index   <= w_bin;
            r_res.bin_count   <= w_count;
            r_res.flat_vector <= w_ratio.flat_vector;
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule
